FILE: src/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types, widths and tables of the tetrahedron plane clipper
// Coordinate widths, word formats, vertex orderings and the per-step
// descriptor that drives the output sequence.
// ----------------------------------------------------------------------------
`default_nettype none
package tpc_pkg;

  localparam int COORD_BITS = 32;
  localparam int DX_W   = COORD_BITS + 1;         // vertex minus plane point
  localparam int PROD_W = COORD_BITS + DX_W;      // one distance term
  localparam int DIST_W = PROD_W + 2;             // sum of three terms
  localparam int DEN_W  = DIST_W + 1;             // |d_b - d_a|
  localparam int MAG_W  = COORD_BITS;             // |b - a| per axis
  localparam int LO_W   = (DIST_W + 1) / 2;       // low split of |d_a|
  localparam int HI_W   = DIST_W - LO_W;
  localparam int N_W    = DIST_W + MAG_W;         // dividend width
  localparam int QW     = MAG_W;                  // quotient bits
  localparam int RW     = DEN_W;                  // partial remainder
  localparam int NREG   = 6;
  localparam int IDX_W  = 3;
  localparam int STEP_W = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_PLANE_X, REG_PLANE_Y, REG_PLANE_Z,
    REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z
  } reg_idx_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    coord_t v0_x; coord_t v0_y; coord_t v0_z;
    coord_t v1_x; coord_t v1_y; coord_t v1_z;
    coord_t v2_x; coord_t v2_y; coord_t v2_z;
    coord_t v3_x; coord_t v3_y; coord_t v3_z;
  } in_item_t;

  typedef struct packed {
    coord_t      out_x;
    coord_t      out_y;
    coord_t      out_z;
    logic [1:0]  piece_index;
    logic [1:0]  corner_index;
    logic        vertex_valid;
    logic        last;
  } out_item_t;

  // one output vertex: plain vertex a, or the cut point on edge a->b
  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic       cut;
    logic       valid;
    logic       last;
    logic [1:0] piece;
    logic [1:0] corner;
  } desc_t;

  localparam logic [1:0] OPP_TAB [4][3] = '{
    '{2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd1}, '{2'd0, 2'd1, 2'd2}};

  // remaining two corners for each kept pair (x0, x1)
  localparam logic [1:0] PAIR_TAB [6][2] = '{
    '{2'd2, 2'd3}, '{2'd3, 2'd1}, '{2'd1, 2'd2},
    '{2'd0, 2'd3}, '{2'd2, 2'd0}, '{2'd0, 2'd1}};

  function automatic desc_t pick(input logic [1:0] a, input logic [1:0] b,
                                 input logic c);
    desc_t d;
    d = '0;
    d.a = a;
    d.b = b;
    d.cut = c;
    d.valid = 1'b1;
    return d;
  endfunction

  function automatic desc_t desc_f(input logic [3:0] dead,
                                   input logic [STEP_W-1:0] step);
    desc_t d;
    logic [2:0] nd;
    logic [1:0] kd, kk, k0, k1, e0, e1, e2, x2, x3;
    logic [2:0] sel;
    logic [1:0] found;
    logic [STEP_W-1:0] n_items;
    nd = '0; kd = '0; kk = '0; k0 = '0; k1 = '0; found = '0;
    for (int i = 3; i >= 0; i--) begin
      if (dead[i]) kd = 2'(i);
      else kk = 2'(i);
      nd = nd + 3'(dead[i]);
    end
    for (int i = 0; i < 4; i++) begin
      if (!dead[i] && found == 2'd0) begin
        k0 = 2'(i);
        found = 2'd1;
      end else if (!dead[i] && found == 2'd1) begin
        k1 = 2'(i);
        found = 2'd2;
      end
    end
    if (k0 == 2'd0) sel = 3'(k1) - 3'd1;
    else if (k0 == 2'd1) sel = 3'(k1) + 3'd1;
    else sel = 3'd5;
    if (sel > 3'd5) sel = 3'd0;
    x2 = PAIR_TAB[sel][0];
    x3 = PAIR_TAB[sel][1];
    e0 = (nd == 3'd3) ? OPP_TAB[kk][0] : OPP_TAB[kd][0];
    e1 = (nd == 3'd3) ? OPP_TAB[kk][1] : OPP_TAB[kd][1];
    e2 = (nd == 3'd3) ? OPP_TAB[kk][2] : OPP_TAB[kd][2];
    d = '0;
    n_items = 4'd1;
    unique case (nd)
      3'd0: begin
        n_items = 4'd4;
        d = pick(step[1:0], step[1:0], 1'b0);
      end
      3'd1: begin
        n_items = 4'd12;
        unique case (step)
          4'd0:  d = pick(e0, e0, 1'b0);
          4'd1:  d = pick(e1, e1, 1'b0);
          4'd2:  d = pick(kd, e0, 1'b1);
          4'd3:  d = pick(e2, e2, 1'b0);
          4'd4:  d = pick(e2, e2, 1'b0);
          4'd5:  d = pick(kd, e0, 1'b1);
          4'd6:  d = pick(kd, e2, 1'b1);
          4'd7:  d = pick(kd, e1, 1'b1);
          4'd8:  d = pick(e1, e1, 1'b0);
          4'd9:  d = pick(e2, e2, 1'b0);
          4'd10: d = pick(kd, e1, 1'b1);
          default: d = pick(kd, e0, 1'b1);
        endcase
      end
      3'd2: begin
        n_items = 4'd12;
        unique case (step)
          4'd0:  d = pick(k1, k1, 1'b0);
          4'd1:  d = pick(k0, x3, 1'b1);
          4'd2:  d = pick(k0, x2, 1'b1);
          4'd3:  d = pick(k0, k0, 1'b0);
          4'd4:  d = pick(k0, x3, 1'b1);
          4'd5:  d = pick(k0, x2, 1'b1);
          4'd6:  d = pick(k1, x3, 1'b1);
          4'd7:  d = pick(k1, k1, 1'b0);
          4'd8:  d = pick(k1, x3, 1'b1);
          4'd9:  d = pick(k0, x2, 1'b1);
          4'd10: d = pick(k1, x2, 1'b1);
          default: d = pick(k1, k1, 1'b0);
        endcase
      end
      3'd3: begin
        n_items = 4'd4;
        unique case (step[1:0])
          2'd0: d = pick(kk, e0, 1'b1);
          2'd1: d = pick(kk, e1, 1'b1);
          2'd2: d = pick(kk, e2, 1'b1);
          default: d = pick(kk, kk, 1'b0);
        endcase
      end
      default: begin
        d = '0;   // clipped away: one empty word
      end
    endcase
    d.piece  = step[3:2];
    d.corner = step[1:0];
    if (!d.valid) begin
      d.piece  = '0;
      d.corner = '0;
    end
    d.last = (step == n_items - 4'd1);
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: src/tpc_intf.sv
// ----------------------------------------------------------------------------
// tpc_in_if / tpc_out_if: valid-ready channels of the clipper
// Input carries one tetrahedron, output one vertex word.
// ----------------------------------------------------------------------------
`default_nettype none
interface tpc_in_if;
  logic               valid;
  logic               ready;
  tpc_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tpc_out_if;
  logic               valid;
  logic               ready;
  tpc_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/tetrahedron_plane_clipper.sv
// ----------------------------------------------------------------------------
// tetrahedron_plane_clipper: clips one tetrahedron against a plane
// Signed distances, case selection, vertex sequencing and edge cuts by a
// pipelined restoring divider, one output vertex word per cycle while out_o is not stalled.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  in_i      in   valid/ready    four vertices, Q16.16
//  out_o     out  valid/ready    one vertex + piece/corner/valid/last
//  cfg       in   cfg_we_i       plane point and normal, index cfg_idx_i
//
// A tetrahedron occupies the vertex sequencer until its last output word is
// sequenced: 4 words (kept whole or one piece), 12 (three pieces) or 1
// (clipped away). The pipeline has 3 distance stages, the sequencer, the edge
// setup/multiply stages, the divider stages and the output register.
// Reset clears valid bits, the sequencer count and the plane registers.
// A stall on out_o freezes the whole pipeline; nothing is dropped.
`default_nettype none
module tetrahedron_plane_clipper (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tpc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tpc_pkg::COORD_BITS-1:0] cfg_data_i,
  tpc_in_if.sink                             in_i,
  tpc_out_if.source                          out_o
);

  localparam int CB = tpc_pkg::COORD_BITS;

  tpc_pkg::coord_t regs_q [tpc_pkg::NREG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tpc_pkg::NREG; i++) regs_q[i] <= '0;
    end else if (cfg_we_i && cfg_idx_i < tpc_pkg::IDX_W'(tpc_pkg::NREG)) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  tpc_pkg::coord_t plane [3];
  tpc_pkg::coord_t nrm [3];
  assign plane[0] = regs_q[tpc_pkg::REG_PLANE_X];
  assign plane[1] = regs_q[tpc_pkg::REG_PLANE_Y];
  assign plane[2] = regs_q[tpc_pkg::REG_PLANE_Z];
  assign nrm[0]   = regs_q[tpc_pkg::REG_NORMAL_X];
  assign nrm[1]   = regs_q[tpc_pkg::REG_NORMAL_Y];
  assign nrm[2]   = regs_q[tpc_pkg::REG_NORMAL_Z];

  logic en, front_en, ex_free;
  logic out_v_q;
  assign en = !out_v_q || out_o.ready;

  // ---------------- distance stages ----------------
  tpc_pkg::coord_t vin [4][3];
  assign vin[0][0] = in_i.payload.v0_x; assign vin[0][1] = in_i.payload.v0_y;
  assign vin[0][2] = in_i.payload.v0_z; assign vin[1][0] = in_i.payload.v1_x;
  assign vin[1][1] = in_i.payload.v1_y; assign vin[1][2] = in_i.payload.v1_z;
  assign vin[2][0] = in_i.payload.v2_x; assign vin[2][1] = in_i.payload.v2_y;
  assign vin[2][2] = in_i.payload.v2_z; assign vin[3][0] = in_i.payload.v3_x;
  assign vin[3][1] = in_i.payload.v3_y; assign vin[3][2] = in_i.payload.v3_z;

  logic s1_v_q, s2_v_q, s3_v_q;
  tpc_pkg::coord_t v1_q [4][3], v2_q [4][3], v3_q [4][3];
  logic signed [tpc_pkg::DX_W-1:0]   dx_q   [4][3];
  logic signed [tpc_pkg::PROD_W-1:0] prod_q [4][3];
  logic signed [tpc_pkg::DIST_W-1:0] dist_q [4];
  logic [3:0] dead_q;
  logic signed [tpc_pkg::DIST_W-1:0] dist_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dist_d[i] = tpc_pkg::DIST_W'(prod_q[i][0]) + tpc_pkg::DIST_W'(prod_q[i][1])
                + tpc_pkg::DIST_W'(prod_q[i][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (front_en) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          v1_q[i][k]   <= vin[i][k];
          dx_q[i][k]   <= tpc_pkg::DX_W'(vin[i][k]) - tpc_pkg::DX_W'(plane[k]);
          v2_q[i][k]   <= v1_q[i][k];
          prod_q[i][k] <= tpc_pkg::PROD_W'(nrm[k]) * tpc_pkg::PROD_W'(dx_q[i][k]);
          v3_q[i][k]   <= v2_q[i][k];
        end
        dist_q[i] <= dist_d[i];
        dead_q[i] <= dist_d[i] > 0;
      end
    end
  end

  // ---------------- vertex sequencer ----------------
  logic ex_v_q;
  logic [tpc_pkg::STEP_W-1:0] ex_cnt_q;
  tpc_pkg::coord_t ex_vtx_q [4][3];
  logic signed [tpc_pkg::DIST_W-1:0] ex_dist_q [4];
  logic [3:0] ex_dead_q;
  tpc_pkg::desc_t desc;

  assign desc     = tpc_pkg::desc_f(ex_dead_q, ex_cnt_q);
  assign ex_free  = !ex_v_q || desc.last;
  assign front_en = en && ex_free;
  assign in_i.ready = front_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q   <= 1'b0;
      ex_cnt_q <= '0;
    end else if (front_en) begin
      ex_v_q   <= s3_v_q;
      ex_cnt_q <= '0;
    end else if (en && ex_v_q) begin
      ex_cnt_q <= ex_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      ex_vtx_q  <= v3_q;
      ex_dist_q <= dist_q;
      ex_dead_q <= dead_q;
    end
  end

  // ---------------- edge setup ----------------
  logic c0_v_q, c1_v_q, c2_v_q;
  tpc_pkg::desc_t c0_d_q, c1_d_q, c2_d_q;
  tpc_pkg::coord_t c0_va_q [3], c0_vb_q [3], c1_va_q [3], c2_va_q [3];
  logic signed [tpc_pkg::DIST_W-1:0] c0_da_q, c0_db_q;
  logic [tpc_pkg::DIST_W-1:0] c1_num_q;
  logic [tpc_pkg::DEN_W-1:0]  c1_den_q, c2_den_q;
  logic [tpc_pkg::MAG_W-1:0]  c1_mag_q [3], c2_mag_q [3];
  logic c1_neg_q [3], c2_neg_q [3];
  logic [tpc_pkg::LO_W+tpc_pkg::MAG_W-1:0] c2_pl_q [3];
  logic [tpc_pkg::HI_W+tpc_pkg::MAG_W-1:0] c2_ph_q [3];

  logic signed [tpc_pkg::DX_W-1:0]  diff [3];
  logic signed [tpc_pkg::DEN_W-1:0] dden;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = tpc_pkg::DX_W'(c0_vb_q[k]) - tpc_pkg::DX_W'(c0_va_q[k]);
    end
    dden = tpc_pkg::DEN_W'(c0_db_q) - tpc_pkg::DEN_W'(c0_da_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_v_q <= 1'b0;
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
    end else if (en) begin
      c0_v_q <= ex_v_q;
      c1_v_q <= c0_v_q;
      c2_v_q <= c1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_d_q  <= desc;
      c0_da_q <= ex_dist_q[desc.a];
      c0_db_q <= ex_dist_q[desc.b];
      for (int k = 0; k < 3; k++) begin
        c0_va_q[k] <= desc.valid ? ex_vtx_q[desc.a][k] : '0;
        c0_vb_q[k] <= ex_vtx_q[desc.b][k];
      end
      c1_d_q   <= c0_d_q;
      c1_num_q <= c0_da_q[tpc_pkg::DIST_W-1] ? tpc_pkg::DIST_W'(-c0_da_q)
                                             : tpc_pkg::DIST_W'(c0_da_q);
      c1_den_q <= dden[tpc_pkg::DEN_W-1] ? tpc_pkg::DEN_W'(-dden)
                                         : tpc_pkg::DEN_W'(dden);
      for (int k = 0; k < 3; k++) begin
        c1_va_q[k]  <= c0_va_q[k];
        c1_neg_q[k] <= diff[k][tpc_pkg::DX_W-1];
        c1_mag_q[k] <= diff[k][tpc_pkg::DX_W-1] ? tpc_pkg::MAG_W'(-diff[k])
                                                : tpc_pkg::MAG_W'(diff[k]);
      end
      c2_d_q   <= c1_d_q;
      c2_den_q <= c1_den_q;
      for (int k = 0; k < 3; k++) begin
        c2_va_q[k]  <= c1_va_q[k];
        c2_neg_q[k] <= c1_neg_q[k];
        c2_mag_q[k] <= c1_mag_q[k];
        c2_pl_q[k]  <= (tpc_pkg::LO_W+tpc_pkg::MAG_W)'(c1_num_q[tpc_pkg::LO_W-1:0])
                     * (tpc_pkg::LO_W+tpc_pkg::MAG_W)'(c1_mag_q[k]);
        c2_ph_q[k]  <= (tpc_pkg::HI_W+tpc_pkg::MAG_W)'(c1_num_q[tpc_pkg::DIST_W-1:tpc_pkg::LO_W])
                     * (tpc_pkg::HI_W+tpc_pkg::MAG_W)'(c1_mag_q[k]);
      end
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  localparam int NS = tpc_pkg::QW + 1;
  logic dv_v_q [NS];
  tpc_pkg::desc_t dv_d_q [NS];
  tpc_pkg::coord_t dv_va_q [NS][3];
  logic dv_neg_q [NS][3];
  logic [tpc_pkg::MAG_W-1:0] dv_mag_q [NS][3];
  logic [tpc_pkg::DEN_W-1:0] dv_den_q [NS];
  logic [tpc_pkg::RW-1:0] dv_r_q [NS][3];
  logic [tpc_pkg::QW-1:0] dv_lo_q [NS][3];
  logic [tpc_pkg::QW-1:0] dv_qt_q [NS][3];

  logic [tpc_pkg::N_W-1:0] nprod [3];
  logic [tpc_pkg::RW:0] trial [NS-1][3];
  logic take [NS-1][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nprod[k] = (tpc_pkg::N_W'(c2_ph_q[k]) << tpc_pkg::LO_W) + tpc_pkg::N_W'(c2_pl_q[k]);
    end
    for (int j = 0; j < NS - 1; j++) begin
      for (int k = 0; k < 3; k++) begin
        trial[j][k] = {dv_r_q[j][k], dv_lo_q[j][k][tpc_pkg::QW-1]};
        take[j][k]  = trial[j][k] >= (tpc_pkg::RW+1)'(dv_den_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NS; j++) dv_v_q[j] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= c2_v_q;
      for (int j = 1; j < NS; j++) dv_v_q[j] <= dv_v_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_d_q[0]   <= c2_d_q;
      dv_den_q[0] <= c2_den_q;
      for (int k = 0; k < 3; k++) begin
        dv_va_q[0][k]  <= c2_va_q[k];
        dv_neg_q[0][k] <= c2_neg_q[k];
        dv_mag_q[0][k] <= c2_mag_q[k];
        dv_r_q[0][k]   <= tpc_pkg::RW'(nprod[k][tpc_pkg::N_W-1:tpc_pkg::QW]);
        dv_lo_q[0][k]  <= nprod[k][tpc_pkg::QW-1:0];
        dv_qt_q[0][k]  <= '0;
      end
      for (int j = 1; j < NS; j++) begin
        dv_d_q[j]   <= dv_d_q[j-1];
        dv_den_q[j] <= dv_den_q[j-1];
        for (int k = 0; k < 3; k++) begin
          dv_va_q[j][k]  <= dv_va_q[j-1][k];
          dv_neg_q[j][k] <= dv_neg_q[j-1][k];
          dv_mag_q[j][k] <= dv_mag_q[j-1][k];
          dv_r_q[j][k]   <= take[j-1][k]
                          ? tpc_pkg::RW'(trial[j-1][k] - (tpc_pkg::RW+1)'(dv_den_q[j-1]))
                          : tpc_pkg::RW'(trial[j-1][k]);
          dv_lo_q[j][k]  <= dv_lo_q[j-1][k] << 1;
          dv_qt_q[j][k]  <= {dv_qt_q[j-1][k][tpc_pkg::QW-2:0], take[j-1][k]};
        end
      end
    end
  end

  // ---------------- rounding, clamp, output register ----------------
  localparam int L = NS - 1;
  logic [tpc_pkg::QW:0] qr [3];
  logic [tpc_pkg::DX_W-1:0] res [3];
  tpc_pkg::coord_t res_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qr[k] = (tpc_pkg::QW+1)'(dv_qt_q[L][k])
            + (tpc_pkg::QW+1)'({dv_r_q[L][k], 1'b0} >= (tpc_pkg::RW+1)'(dv_den_q[L]));
      if (qr[k] > (tpc_pkg::QW+1)'(dv_mag_q[L][k])) qr[k] = (tpc_pkg::QW+1)'(dv_mag_q[L][k]);
      res[k] = dv_neg_q[L][k] ? tpc_pkg::DX_W'(dv_va_q[L][k]) - tpc_pkg::DX_W'(qr[k])
                              : tpc_pkg::DX_W'(dv_va_q[L][k]) + tpc_pkg::DX_W'(qr[k]);
      res_c[k] = dv_d_q[L].cut ? res[k][CB-1:0] : dv_va_q[L][k];
    end
  end

  tpc_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_x        <= res_c[0];
      out_q.out_y        <= res_c[1];
      out_q.out_z        <= res_c[2];
      out_q.piece_index  <= dv_d_q[L].piece;
      out_q.corner_index <= dv_d_q[L].corner;
      out_q.vertex_valid <= dv_d_q[L].valid;
      out_q.last         <= dv_d_q[L].last;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

  // ---------------- checks ----------------
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.vertex_valid |-> out_q.last)
    else $error("empty word without last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.vertex_valid |->
      out_q.out_x == 0 && out_q.out_y == 0 && out_q.out_z == 0)
    else $error("empty word carries geometry");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.last && out_q.vertex_valid |-> out_q.corner_index == 2'd3)
    else $error("last word not at final corner");

  a_piece_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.piece_index != 2'd3)
    else $error("piece index out of range");

endmodule
`default_nettype wire

FILE: tb/tpc_tb_intf_note.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpc_tb_types: row kinds and directed-table row used by the testbench
// Keeps the directed-table types out of the testbench top.
// ----------------------------------------------------------------------------
package tpc_tb_types;

  // how the expected words of a directed row are obtained
  typedef enum logic [1:0] {ROW_MODEL, ROW_WHOLE, ROW_GONE} row_kind_e;

  typedef struct {
    int                 phase;
    row_kind_e          kind;
    tpc_pkg::in_item_t  tet;
  } tet_row_t;
endpackage

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the tetrahedron plane clipper
// Directed tetrahedra for every clip case and the plane extremes, then random
// tetrahedra under three plane settings (random idling on both channels, then a
// long output stall). Words must match the bit-exact clip task or typed rows.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [127:0] dist_t;
  typedef logic signed [tpc_pkg::COORD_BITS-1:0] pt_t [3];

  localparam int LIMIT  = 300000;
  localparam int SETTLE = 80;
  localparam int N_DIR  = 23;
  localparam int CB     = tpc_pkg::COORD_BITS;

  localparam logic [1:0] FACE_OPP [4][3] = '{
    '{2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd3}, '{2'd0, 2'd3, 2'd1}, '{2'd0, 2'd1, 2'd2}};
  localparam logic [1:0] KEPT_PAIR [6][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd1, 2'd3, 2'd2, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd1}};

  logic clk_i, rst_ni, cfg_we_i;
  logic [tpc_pkg::IDX_W-1:0] cfg_idx_i;
  logic [tpc_pkg::COORD_BITS-1:0] cfg_data_i;

  tpc_in_if  in_if ();
  tpc_out_if out_if ();

  tetrahedron_plane_clipper uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_i(in_if), .out_o(out_if));

  tpc_pkg::coord_t        plane_pt [3];
  tpc_pkg::coord_t        plane_n  [3];
  tpc_pkg::out_item_t     vertex_q [$];
  tpc_tb_types::tet_row_t dir_tab  [N_DIR];
  int                     send_idle, recv_idle, hold_left, cycles, mismatches;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // clip calculation
  // --------------------------------------------------------------------------
  function automatic pt_t cut_point(pt_t v [4], dist_t d [4], int a, int b);
    pt_t r;
    logic [127:0] num, den, prod, q;
    logic signed [CB:0] diff;
    logic [CB:0] mag;
    r = v[a];
    num = d[a] < 0 ? -d[a] : d[a];
    den = (d[b] - d[a]) < 0 ? -(d[b] - d[a]) : (d[b] - d[a]);
    if (den == 0) return r;
    for (int k = 0; k < 3; k++) begin
      diff = $signed({v[b][k][CB-1], v[b][k]}) - $signed({v[a][k][CB-1], v[a][k]});
      mag  = diff < 0 ? -diff : diff;
      prod = num * 128'(mag);
      q    = (2 * prod + den) / (2 * den);   // nearest, halves toward b
      if (q > 128'(mag)) q = 128'(mag);
      r[k] = diff < 0 ? v[a][k] - CB'(q) : v[a][k] + CB'(q);
    end
    return r;
  endfunction

  task automatic predict_clip(input tpc_pkg::in_item_t t);
    pt_t v [4];
    pt_t pc [12];
    dist_t d [4];
    logic [3:0] dead;
    int ndead, n, kd, kk, m, sel;
    int keep [2];
    logic [1:0] e [3];
    logic [1:0] x [4];
    pt_t p0, p1, p2, p3;
    tpc_pkg::out_item_t w;
    v[0] = '{t.v0_x, t.v0_y, t.v0_z}; v[1] = '{t.v1_x, t.v1_y, t.v1_z};
    v[2] = '{t.v2_x, t.v2_y, t.v2_z}; v[3] = '{t.v3_x, t.v3_y, t.v3_z};
    ndead = 0;
    for (int i = 0; i < 4; i++) begin
      d[i] = 0;
      for (int k = 0; k < 3; k++)
        d[i] += dist_t'(plane_n[k]) * (dist_t'(v[i][k]) - dist_t'(plane_pt[k]));
      dead[i] = d[i] > 0;
      ndead += dead[i];
    end
    kd = 0; kk = 0;
    for (int i = 3; i >= 0; i--) begin
      if (dead[i]) kd = i;
      else kk = i;
    end
    n = 0;
    case (ndead)
      0: begin
        for (int j = 0; j < 4; j++) pc[j] = v[j];
        n = 4;
      end
      1: begin
        e = FACE_OPP[kd];
        p0 = cut_point(v, d, kd, e[0]);
        p1 = cut_point(v, d, kd, e[1]);
        p2 = cut_point(v, d, kd, e[2]);
        pc = '{v[e[0]], v[e[1]], p0, v[e[2]], v[e[2]], p0, p2, p1,
               v[e[1]], v[e[2]], p1, p0};
        n = 12;
      end
      2: begin
        m = 0; keep = '{0, 0};
        for (int i = 0; i < 4; i++)
          if (!dead[i] && m < 2) begin
            keep[m] = i;
            m++;
          end
        sel = keep[0] == 0 ? keep[1] - 1 : (keep[0] == 1 ? keep[1] + 1 : 5);
        if (sel < 0 || sel > 5) sel = 0;
        x = KEPT_PAIR[sel];
        p0 = cut_point(v, d, x[0], x[3]);
        p1 = cut_point(v, d, x[1], x[3]);
        p2 = cut_point(v, d, x[1], x[2]);
        p3 = cut_point(v, d, x[0], x[2]);
        pc = '{v[x[1]], p0, p3, v[x[0]], p0, p3, p1, v[x[1]],
               p1, p3, p2, v[x[1]]};
        n = 12;
      end
      3: begin
        e = FACE_OPP[kk];
        pc[0] = cut_point(v, d, kk, e[0]);
        pc[1] = cut_point(v, d, kk, e[1]);
        pc[2] = cut_point(v, d, kk, e[2]);
        pc[3] = v[kk];
        n = 4;
      end
      default: n = 0;
    endcase
    if (n == 0) begin
      w = '0;
      w.last = 1'b1;
      vertex_q.insert(vertex_q.size(), w);
    end
    for (int j = 0; j < n; j++) begin
      w.out_x = pc[j][0]; w.out_y = pc[j][1]; w.out_z = pc[j][2];
      w.piece_index  = 2'(j / 4);
      w.corner_index = 2'(j % 4);
      w.vertex_valid = 1'b1;
      w.last = (j == n - 1);
      vertex_q.insert(vertex_q.size(), w);
    end
  endtask

  // typed-in expectations for rows that need no arithmetic
  task automatic expect_plain(input tpc_tb_types::tet_row_t r);
    tpc_pkg::out_item_t w;
    tpc_pkg::coord_t c [12];
    if (r.kind == tpc_tb_types::ROW_GONE) begin
      w = '0;
      w.last = 1'b1;
      vertex_q.insert(vertex_q.size(), w);
    end else begin
      c = '{r.tet.v0_x, r.tet.v0_y, r.tet.v0_z, r.tet.v1_x, r.tet.v1_y, r.tet.v1_z,
            r.tet.v2_x, r.tet.v2_y, r.tet.v2_z, r.tet.v3_x, r.tet.v3_y, r.tet.v3_z};
      for (int j = 0; j < 4; j++) begin
        w = '{c[3*j], c[3*j+1], c[3*j+2], 2'd0, 2'(j), 1'b1, j == 3};
        vertex_q.insert(vertex_q.size(), w);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic write_plane(input tpc_pkg::coord_t px, py, pz, nx, ny, nz);
    tpc_pkg::coord_t val [6];
    tpc_pkg::reg_idx_e idx [6];
    val = '{px, py, pz, nx, ny, nz};
    idx = '{tpc_pkg::REG_PLANE_X, tpc_pkg::REG_PLANE_Y, tpc_pkg::REG_PLANE_Z,
            tpc_pkg::REG_NORMAL_X, tpc_pkg::REG_NORMAL_Y, tpc_pkg::REG_NORMAL_Z};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    plane_pt = '{px, py, pz};
    plane_n  = '{nx, ny, nz};
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // offers one tetrahedron, returns at its acceptance edge with valid still high
  task automatic send_tet(input tpc_pkg::in_item_t t);
    while ($urandom_range(0, 99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= t;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic tpc_pkg::coord_t rand_coord(input bit near);
    return near ? tpc_pkg::coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000
                : tpc_pkg::coord_t'($urandom);
  endfunction

  function automatic tpc_pkg::in_item_t rand_tet;
    tpc_pkg::in_item_t t;
    bit near;
    tpc_pkg::coord_t c [12];
    near = $urandom_range(0, 9) < 7;
    foreach (c[i]) c[i] = rand_coord(near);
    t = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
    return t;
  endfunction

  function automatic tpc_tb_types::tet_row_t mk_row(input int ph,
                                                    input tpc_tb_types::row_kind_e kd,
                                                    input tpc_pkg::coord_t x0, x1, x2, x3);
    tpc_tb_types::tet_row_t r;
    r.phase = ph;
    r.kind  = kd;
    r.tet = {x0, 32'sh0001_8000, -32'sh0000_4000,
             x1, -32'sh0002_0000, 32'sh0003_0000,
             x2, 32'sh0000_c000, 32'sh0001_0000,
             x3, 32'sh0004_4000, -32'sh0002_8000};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // receiver and checker
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  always @(posedge clk_i) begin
    tpc_pkg::out_item_t e, a;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      a = out_if.payload;
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", a);
      end else begin
        e = vertex_q.pop_front();
        if (a.out_x !== e.out_x || a.out_y !== e.out_y || a.out_z !== e.out_z ||
            a.piece_index !== e.piece_index || a.corner_index !== e.corner_index ||
            a.vertex_valid !== e.vertex_valid || a.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, a);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    tpc_pkg::coord_t xs [4];
    int ph;
    send_idle = 36;
    recv_idle = 84;
    plane_pt = '{0, 0, 0};
    plane_n  = '{0, 0, 0};
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= tpc_pkg::REG_PLANE_X;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;

    // zero normal after reset: everything passes through
    dir_tab[0] = mk_row(0, tpc_tb_types::ROW_WHOLE, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000, 32'sh8000_0000);
    dir_tab[0].tet = {12{32'sh8000_0000}};
    dir_tab[1] = dir_tab[0];
    dir_tab[1].tet = {12{32'sh7fff_ffff}};
    dir_tab[2] = mk_row(0, tpc_tb_types::ROW_WHOLE, 32'sh7fff_ffff, 32'sh8000_0000, 0, -1);
    // plane x = 0, normal +x: every removal pattern, vertex 0 on the plane first
    dir_tab[3] = mk_row(1, tpc_tb_types::ROW_WHOLE, 0, -32'sh0003_0000,
                        -32'sh0001_0000, -1);
    for (int m = 1; m < 16; m++) begin
      for (int i = 0; i < 4; i++)
        xs[i] = m[i] ? 32'sh0002_0000 + i * 32'sh0000_5000
                     : -32'sh0003_0000 + i * 32'sh0000_7000;
      dir_tab[3 + m] = mk_row(1, m == 15 ? tpc_tb_types::ROW_GONE : tpc_tb_types::ROW_MODEL,
                              xs[0], xs[1], xs[2], xs[3]);
    end
    dir_tab[19] = mk_row(1, tpc_tb_types::ROW_MODEL, 32'sh7fff_ffff, 32'sh8000_0000,
                         32'sh8000_0000, 32'sh8000_0000);
    // extreme plane point and normal
    for (int i = 20; i < N_DIR; i++) begin
      dir_tab[i].phase = 2;
      dir_tab[i].kind  = tpc_tb_types::ROW_MODEL;
      dir_tab[i].tet   = rand_tet();
    end
    dir_tab[22].tet = {32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                       {9{32'sh8000_0000}}};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ph = 0;
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_tab[r].phase != ph) begin
        drain();
        ph = dir_tab[r].phase;
        if (ph == 1) write_plane(0, 0, 0, 32'sh0001_0000, 0, 0);
        else write_plane(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                         32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
      end
      send_tet(dir_tab[r].tet);
      if (dir_tab[r].kind == tpc_tb_types::ROW_MODEL) predict_clip(dir_tab[r].tet);
      else expect_plain(dir_tab[r]);
    end

    for (int p = 0; p < 3; p++) begin
      drain();
      case (p)
        0: write_plane(rand_coord(1), rand_coord(1), rand_coord(1),
                       rand_coord(1), rand_coord(1), rand_coord(1));
        1: begin
          send_idle = 84;
          recv_idle = 36;
          write_plane(tpc_pkg::coord_t'($urandom), tpc_pkg::coord_t'($urandom),
                      tpc_pkg::coord_t'($urandom), tpc_pkg::coord_t'($urandom),
                      tpc_pkg::coord_t'($urandom), tpc_pkg::coord_t'($urandom));
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_plane(rand_coord(1), 0, rand_coord(1), -32'sh0000_8000,
                      32'sh0001_0000, rand_coord(1));
          hold_left = 400;   // long output stall while tetrahedra keep coming
        end
      endcase
      for (int i = 0; i < 50; i++) begin
        tpc_pkg::in_item_t t;
        t = rand_tet();
        send_tet(t);
        predict_clip(t);
      end
    end

    drain();
    if (mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
